// ===== rtl/mhic_pkg.sv =====
// Shared constants, codes and types of the magnetometer hard-iron calibration block.
`timescale 1ns / 1ps
`default_nettype none
package mhic_pkg;

	localparam int AXES    = 3;
	localparam int RAW_W   = 16;
	localparam int OFF_W   = 12;
	localparam int FIELD_W = 19;
	localparam int SCALE_W = 16;
	localparam int VAL_W   = 17;
	localparam int PROD_W  = 34;
	localparam int CFG_IDX_W = 2;

	localparam int SCALE_FRAC_BITS_DEF = 14;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd16384;

	localparam logic signed [RAW_W-1:0] RAW_HIGH = 16'sd2047;
	localparam logic signed [RAW_W-1:0] RAW_LOW  = -16'sd2048;
	localparam logic signed [OFF_W-1:0] OFF_MAX  = 12'sd2047;
	localparam logic signed [OFF_W-1:0] OFF_MIN  = -12'sd2048;
	localparam int FIELD_MAX = 262143;
	localparam int FIELD_MIN = -262144;

	localparam logic [1:0] MODE_MEAS = 2'd0;
	localparam logic [1:0] MODE_CAL  = 2'd1;
	localparam logic [1:0] MODE_FIN  = 2'd2;
	localparam logic [1:0] MODE_LOAD = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 2'd2;

	// State update commands from the control unit to each axis lane.
	typedef struct packed {
		logic meas;
		logic clr;
		logic seed;
		logic widen;
		logic set_mid;
		logic load;
	} mhic_cmd_t;

	// Per-axis findings that the control unit merges.
	typedef struct packed {
		logic in_range;
		logic nonzero;
		logic mid_zero;
	} mhic_stat_t;

	// Pipeline stage load enables.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} mhic_pipe_t;

	// Per-transaction flags that travel with the lane data.
	typedef struct packed {
		logic sample_ok;
		logic upd;
		logic healthy;
		logic failed;
	} mhic_res_t;

endpackage
`default_nettype wire

// ===== rtl/mhic_sample_if.sv =====
// Input channel interface carrying one command and three-axis sample.
`timescale 1ns / 1ps
`default_nettype none
interface mhic_sample_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [15:0] raw_x;
	logic signed [15:0] raw_y;
	logic signed [15:0] raw_z;

	modport source (output valid, mode, raw_x, raw_y, raw_z, input ready);
	modport sink (input valid, mode, raw_x, raw_y, raw_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/mhic_result_if.sv =====
// Output channel interface carrying one corrected or calibration result.
`timescale 1ns / 1ps
`default_nettype none
interface mhic_result_if;
	logic               valid;
	logic               ready;
	logic               sample_ok;
	logic signed [18:0] field_x;
	logic signed [18:0] field_y;
	logic signed [18:0] field_z;
	logic               healthy;
	logic               calibration_failed;

	modport source (output valid, sample_ok, field_x, field_y, field_z, healthy,
		calibration_failed, input ready);
	modport sink (input valid, sample_ok, field_x, field_y, field_z, healthy,
		calibration_failed, output ready);
endinterface
`default_nettype wire

// ===== rtl/mag_hard_iron_calibrate_correct.sv =====
// Top level of the magnetometer hard-iron calibration and correction block.
//
//   Channel  Dir  Handshake     Payload
//   sample   in   valid/ready   mode, raw_x, raw_y, raw_z
//   result   out  valid/ready   sample_ok, field_x/y/z, healthy, calibration_failed
//   cfg      in   cfg_wr_en     cfg_index, cfg_data (scale_x, scale_y, scale_z)
//
// One transaction is accepted per cycle unless the pipeline stalls; its result passes
// state update and lane difference, gain multiply, and round and output register.
// Calibration state is updated in the accepting cycle, so the next transaction
// sees it at once. A stalled result holds the output register, and the two inner
// stages still take transactions until they fill. Reset clears the calibration state at once.
`timescale 1ns / 1ps
`default_nettype none
module mag_hard_iron_calibrate_correct
	import mhic_pkg::*;
#(
	parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	mhic_sample_if.sink               sample,
	mhic_result_if.source             result,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SCALE_W-1:0]   cfg_data
);

	logic [SCALE_W-1:0]         scale_q [AXES];
	logic signed [RAW_W-1:0]    raw [AXES];
	logic signed [FIELD_W-1:0]  lane_field [AXES];
	logic signed [FIELD_W-1:0]  last_field_q [AXES];
	mhic_stat_t                 lane_stat [AXES];
	mhic_cmd_t                  cmd;
	mhic_pipe_t                 pipe;
	mhic_res_t                  res, res_s1, res_s2;
	logic                       valid_s1, valid_s2, out_valid_q;
	logic                       ready_s1, ready_s2, ready_out, accept;
	logic                       sample_ok_q, healthy_q, failed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				scale_q[i] <= SCALE_RESET;
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SCALE_X: scale_q[0] <= cfg_data;
				REG_SCALE_Y: scale_q[1] <= cfg_data;
				REG_SCALE_Z: scale_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ready_out    = ~out_valid_q | result.ready;
	assign ready_s2     = ~valid_s2 | ready_out;
	assign ready_s1     = ~valid_s1 | ready_s2;
	assign sample.ready = ready_s1;
	assign accept       = sample.valid & ready_s1;
	assign pipe.en_s1   = ready_s1;
	assign pipe.en_s2   = ready_s2;

	assign raw[0] = sample.raw_x;
	assign raw[1] = sample.raw_y;
	assign raw[2] = sample.raw_z;

	mhic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.mode      (sample.mode),
		.lane_stat (lane_stat),
		.cmd       (cmd),
		.res       (res)
	);

	for (genvar g = 0; g < AXES; g++) begin : g_lane
		mhic_lane #(
			.FRAC_BITS (SCALE_FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.raw    (raw[g]),
			.scale  (scale_q[g]),
			.cmd    (cmd),
			.pipe   (pipe),
			.stat   (lane_stat[g]),
			.field  (lane_field[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= sample.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			res_s1 <= res;
		end
		if (ready_s2) begin
			res_s2 <= res_s1;
		end
		if (ready_out && valid_s2) begin
			sample_ok_q <= res_s2.sample_ok;
			healthy_q   <= res_s2.healthy;
			failed_q    <= res_s2.failed;
		end
	end

	// The stored field is the running state; it changes only as transactions retire.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				last_field_q[i] <= '0;
			end
		end else if (ready_out && valid_s2 && res_s2.upd) begin
			for (int i = 0; i < AXES; i++) begin
				last_field_q[i] <= lane_field[i];
			end
		end
	end

	assign result.valid              = out_valid_q;
	assign result.sample_ok          = sample_ok_q;
	assign result.field_x            = last_field_q[0];
	assign result.field_y            = last_field_q[1];
	assign result.field_z            = last_field_q[2];
	assign result.healthy            = healthy_q;
	assign result.calibration_failed = failed_q;

`ifndef SYNTHESIS
	a_fail_not_healthy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.calibration_failed |-> !result.healthy)
		else $error("failed calibration reported as healthy");

	a_fail_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.calibration_failed |-> !result.sample_ok)
		else $error("finish transaction reported a valid sample");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_s2 |=> valid_s2)
		else $error("stalled transaction lost from the multiply stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transaction did not enter the first stage");
`endif

endmodule
`default_nettype wire

// ===== rtl/mhic_lane.sv =====
// One axis lane: offset and min/max state, difference, gain multiply and rounding.
`timescale 1ns / 1ps
`default_nettype none
module mhic_lane
	import mhic_pkg::*;
#(
	parameter int FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic signed [RAW_W-1:0]   raw,
	input  wire logic [SCALE_W-1:0]        scale,
	input  wire mhic_cmd_t                 cmd,
	input  wire mhic_pipe_t                pipe,
	output mhic_stat_t                     stat,
	output logic signed [FIELD_W-1:0]      field
);

	localparam logic signed [PROD_W-1:0] HALF =
		{{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
	localparam logic signed [PROD_W-1:0] QMAX = PROD_W'(FIELD_MAX);
	localparam logic signed [PROD_W-1:0] QMIN = PROD_W'(FIELD_MIN);

	logic signed [OFF_W-1:0]   off_q, min_q, max_q;
	logic signed [OFF_W-1:0]   raw12, new_max, new_min, mid, sat;
	logic signed [OFF_W:0]     span, sum, mid13, diff;
	logic signed [VAL_W-1:0]   meas_val, cal_val;
	logic signed [VAL_W-1:0]   val_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [PROD_W-1:0]  rsum, quo;

	assign raw12   = raw[OFF_W-1:0];
	assign new_max = (raw12 > max_q) ? raw12 : max_q;
	assign new_min = (raw12 < min_q) ? raw12 : min_q;
	assign span    = {new_max[OFF_W-1], new_max} - {new_min[OFF_W-1], new_min};

	// Midpoint rounded toward zero: a negative sum is bumped by one before the shift.
	assign sum   = {max_q[OFF_W-1], max_q} + {min_q[OFF_W-1], min_q};
	assign mid13 = (sum + {{OFF_W{1'b0}}, sum[OFF_W]}) >>> 1;
	assign mid   = mid13[OFF_W-1:0];

	always_comb begin
		if (raw > RAW_HIGH) begin
			sat = OFF_MAX;
		end else if (raw < RAW_LOW) begin
			sat = OFF_MIN;
		end else begin
			sat = raw12;
		end
	end

	assign diff     = {raw12[OFF_W-1], raw12} - {off_q[OFF_W-1], off_q};
	assign meas_val = {diff, 4'b0000};
	assign cal_val  = {span[OFF_W], span, 3'b000};

	assign stat.in_range = (raw < RAW_HIGH) && (raw > RAW_LOW);
	assign stat.nonzero  = (raw != '0);
	assign stat.mid_zero = (mid == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			min_q <= '0;
			max_q <= '0;
		end else begin
			if (cmd.clr) begin
				min_q <= '0;
				max_q <= '0;
			end else if (cmd.seed) begin
				min_q <= raw12;
				max_q <= raw12;
			end else if (cmd.widen) begin
				min_q <= new_min;
				max_q <= new_max;
			end
			if (cmd.set_mid) begin
				off_q <= mid;
			end else if (cmd.load) begin
				off_q <= sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe.en_s1) begin
			val_s1 <= cmd.meas ? meas_val : cal_val;
		end
		if (pipe.en_s2) begin
			prod_s2 <= PROD_W'(val_s1) * PROD_W'($signed({1'b0, scale}));
		end
	end

	// Round half up, then saturate to the field range.
	assign rsum = prod_s2 + HALF;
	assign quo  = rsum >>> FRAC_BITS;

	always_comb begin
		if (quo > QMAX) begin
			field = FIELD_W'(FIELD_MAX);
		end else if (quo < QMIN) begin
			field = FIELD_W'(FIELD_MIN);
		end else begin
			field = quo[FIELD_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mhic_ctrl.sv =====
// Control unit: merges lane findings, decodes the mode and keeps the calibration flags.
`timescale 1ns / 1ps
`default_nettype none
module mhic_ctrl
	import mhic_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [1:0] mode,
	input  wire mhic_stat_t lane_stat [AXES],
	output mhic_cmd_t       cmd,
	output mhic_res_t       res
);

	logic health_q, cal_q, seeded_q;
	logic health_n, cal_n, seeded_n;
	logic all_in, any_nz, all_mid_zero, ok;
	mhic_cmd_t dec;

	always_comb begin
		all_in       = 1'b1;
		any_nz       = 1'b0;
		all_mid_zero = 1'b1;
		for (int i = 0; i < AXES; i++) begin
			all_in       = all_in & lane_stat[i].in_range;
			any_nz       = any_nz | lane_stat[i].nonzero;
			all_mid_zero = all_mid_zero & lane_stat[i].mid_zero;
		end
		ok = all_in & any_nz;
	end

	always_comb begin
		dec           = '0;
		res           = '0;
		health_n      = health_q;
		cal_n         = cal_q;
		seeded_n      = seeded_q;
		unique case (mode)
			MODE_MEAS: begin
				dec.meas      = 1'b1;
				res.sample_ok = ok;
				res.upd       = ok & ~cal_q;
			end
			MODE_CAL: begin
				// A transaction that opens a calibration seeds on a valid sample.
				res.sample_ok = ok;
				dec.clr       = ~cal_q & ~ok;
				dec.seed      = ok & ~(cal_q & seeded_q);
				dec.widen     = ok & cal_q & seeded_q;
				res.upd       = ok & cal_q & seeded_q;
				health_n      = cal_q & health_q;
				cal_n         = 1'b1;
				seeded_n      = (cal_q & seeded_q) | ok;
			end
			MODE_FIN: begin
				if (cal_q) begin
					dec.set_mid = 1'b1;
					res.failed  = all_mid_zero;
					health_n    = ~all_mid_zero;
					cal_n       = 1'b0;
					seeded_n    = 1'b0;
				end
			end
			MODE_LOAD: begin
				dec.load = 1'b1;
				health_n = 1'b1;
				cal_n    = 1'b0;
				seeded_n = 1'b0;
			end
		endcase
		res.healthy = health_n;
	end

	always_comb begin
		cmd         = dec;
		cmd.clr     = dec.clr & accept;
		cmd.seed    = dec.seed & accept;
		cmd.widen   = dec.widen & accept;
		cmd.set_mid = dec.set_mid & accept;
		cmd.load    = dec.load & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			health_q <= 1'b0;
			cal_q    <= 1'b0;
			seeded_q <= 1'b0;
		end else if (accept) begin
			health_q <= health_n;
			cal_q    <= cal_n;
			seeded_q <= seeded_n;
		end
	end

endmodule
`default_nettype wire
